>>> hdl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// Range to Cartesian point: shared package
// Fixed-point constants and the record that travels along the sine cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    localparam int          FRAC_BITS       = 30;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [31:0] HALF_LSB_Q30    = 32'h2000_0000;
    localparam int          TERM_COUNT      = 7;
    localparam int          CELL_STAGES     = 3;
    localparam int          SINE_LATENCY    = 2 + TERM_COUNT * CELL_STAGES + 1;
    localparam int          MIN_RANGE_BITS  = 15;
    localparam logic [14:0] MIN_RANGE_RESET = 15'd19;
    localparam int          COORD_BITS      = 16;
    localparam logic [15:0] COORD_MAX       = 16'd32767;

    typedef struct packed {
        logic [30:0]        term;
        logic [31:0]        t2;
        logic signed [33:0] sum;
    } sine_term_t;

endpackage

`default_nettype wire

>>> hdl/range_to_cartesian_point_unit.sv
// ----------------------------------------------------------------------------
// Range to Cartesian point unit
// Converts a range sample with two binary angles into x, y and z millimetres.
// Throughput is one item per cycle while the output is empty or taken, set by
// the fully pipelined sine cell chain.
// The whole pipeline halts only while a finished output waits to be taken.
// Reset clears all valid flags and sets the minimum range to 19 mm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_to_cartesian_point_unit
    import rtc_pkg::*;
#(
    parameter int ANGLE_BITS  = 16,
    parameter int RANGE_BITS  = 15,
    localparam int IN_DATA_W  = ((RANGE_BITS + 2 * ANGLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [14:0]           cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // range_mm, theta_angle, phi_angle
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // x_mm, y_mm, z_mm
    output logic [47:0]                m_tdata,
    // point_valid
    output logic [0:0]                 m_tuser
);

    localparam int CMP_W = (RANGE_BITS > MIN_RANGE_BITS) ? RANGE_BITS : MIN_RANGE_BITS;
    localparam int MAG_W = RANGE_BITS + 1;
    localparam int SAT_W = (MAG_W > COORD_BITS) ? MAG_W : COORD_BITS;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef struct packed {
        logic [RANGE_BITS-1:0] range;
        logic                  ok;
        logic                  neg_x;
        logic                  neg_y;
        logic                  neg_z;
    } meta_t;

    logic                   en;
    logic [14:0]            min_range_reg;
    logic [RANGE_BITS-1:0]  range_in;
    logic [ANGLE_BITS-1:0]  theta_in;
    logic [ANGLE_BITS-1:0]  phi_in;
    logic [ANGLE_BITS-1:0]  theta_cos;
    logic [ANGLE_BITS-1:0]  phi_cos;
    meta_t                  meta_next;
    meta_t                  meta_pipe [0:SINE_LATENCY-1];
    logic [SINE_LATENCY-1:0] vld_pipe_reg;

    logic [30:0]            sin_th;
    logic [30:0]            cos_th;
    logic [30:0]            sin_ph;
    logic [30:0]            cos_ph;

    logic [61:0]            px_next;
    logic [61:0]            pz_next;
    logic [30+RANGE_BITS:0] py_next;
    logic [30:0]            fx1_reg;
    logic [30:0]            fz1_reg;
    logic [MAG_W-1:0]       y1_reg;
    meta_t                  meta1_reg;
    logic                   vld1_reg;

    logic [30+RANGE_BITS:0] qx_next;
    logic [30+RANGE_BITS:0] qz_next;
    logic [MAG_W-1:0]       x2_reg;
    logic [MAG_W-1:0]       y2_reg;
    logic [MAG_W-1:0]       z2_reg;
    meta_t                  meta2_reg;
    logic                   vld2_reg;

    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;
    logic                   m_tuser_reg;

    function automatic logic [15:0] to_coord(input logic [MAG_W-1:0] mag, input logic neg);
        logic [SAT_W-1:0] wide;
        logic [15:0]      sat;
        wide = SAT_W'(mag);
        sat  = (wide > SAT_W'(COORD_MAX)) ? COORD_MAX : wide[15:0];
        if (neg && (sat != '0))
        begin
            return 16'(~sat + 16'd1);
        end
        return sat;
    endfunction

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign range_in  = s_tdata[RANGE_BITS-1:0];
    assign theta_in  = s_tdata[RANGE_BITS +: ANGLE_BITS];
    assign phi_in    = s_tdata[RANGE_BITS + ANGLE_BITS +: ANGLE_BITS];
    assign theta_cos = theta_in + QUARTER_TURN;
    assign phi_cos   = phi_in + QUARTER_TURN;

    assign meta_next.range = range_in;
    assign meta_next.ok    = CMP_W'(range_in) > CMP_W'(min_range_reg);
    assign meta_next.neg_x = phi_cos[ANGLE_BITS-1] ^ theta_in[ANGLE_BITS-1];
    assign meta_next.neg_y = phi_in[ANGLE_BITS-1];
    assign meta_next.neg_z = phi_cos[ANGLE_BITS-1] ^ theta_cos[ANGLE_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= MIN_RANGE_RESET;
        end
        else if (cfg_wr_en)
        begin
            min_range_reg <= cfg_wr_data;
        end
    end

    rtc_sine_unit #(.ANGLE_BITS(ANGLE_BITS)) u_sin_th
    (
        .clk   (clk),
        .en    (en),
        .angle (theta_in),
        .mag   (sin_th)
    );

    rtc_sine_unit #(.ANGLE_BITS(ANGLE_BITS)) u_cos_th
    (
        .clk   (clk),
        .en    (en),
        .angle (theta_cos),
        .mag   (cos_th)
    );

    rtc_sine_unit #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ph
    (
        .clk   (clk),
        .en    (en),
        .angle (phi_in),
        .mag   (sin_ph)
    );

    rtc_sine_unit #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ph
    (
        .clk   (clk),
        .en    (en),
        .angle (phi_cos),
        .mag   (cos_ph)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_pipe[0] <= meta_next;
            for (int i = 1; i < SINE_LATENCY; i++)
            begin
                meta_pipe[i] <= meta_pipe[i-1];
            end
        end
    end

    assign px_next = 62'(cos_ph) * 62'(sin_th) + 62'(HALF_LSB_Q30);
    assign pz_next = 62'(cos_ph) * 62'(cos_th) + 62'(HALF_LSB_Q30);
    assign py_next = (31 + RANGE_BITS)'(sin_ph) * (31 + RANGE_BITS)'(meta_pipe[SINE_LATENCY-1].range)
                   + (31 + RANGE_BITS)'(HALF_LSB_Q30);
    assign qx_next = (31 + RANGE_BITS)'(fx1_reg) * (31 + RANGE_BITS)'(meta1_reg.range)
                   + (31 + RANGE_BITS)'(HALF_LSB_Q30);
    assign qz_next = (31 + RANGE_BITS)'(fz1_reg) * (31 + RANGE_BITS)'(meta1_reg.range)
                   + (31 + RANGE_BITS)'(HALF_LSB_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx1_reg   <= px_next[60:30];
            fz1_reg   <= pz_next[60:30];
            y1_reg    <= py_next[30+RANGE_BITS:30];
            meta1_reg <= meta_pipe[SINE_LATENCY-1];

            x2_reg    <= qx_next[30+RANGE_BITS:30];
            z2_reg    <= qz_next[30+RANGE_BITS:30];
            y2_reg    <= y1_reg;
            meta2_reg <= meta1_reg;

            if (meta2_reg.ok)
            begin
                m_tdata_reg <= {to_coord(z2_reg, meta2_reg.neg_z),
                                to_coord(y2_reg, meta2_reg.neg_y),
                                to_coord(x2_reg, meta2_reg.neg_x)};
            end
            else
            begin
                m_tdata_reg <= '0;
            end
            m_tuser_reg <= meta2_reg.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_pipe_reg <= {vld_pipe_reg[SINE_LATENCY-2:0], s_tvalid};
            vld1_reg     <= vld_pipe_reg[SINE_LATENCY-1];
            vld2_reg     <= vld1_reg;
            m_tvalid_reg <= vld2_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    a_rejected_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 48'd0)
        else $error("Rejected point carries non-zero coordinates.");

    a_no_min_coord : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)
                     && (m_tdata[47:32] != 16'h8000))
        else $error("Coordinate left the saturation range.");

    a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_pipe_reg) && $stable(vld2_reg))
        else $error("Pipeline advanced while the output was stalled.");
`endif

endmodule

`default_nettype wire

>>> hdl/rtc_sine_cell.sv
// ----------------------------------------------------------------------------
// Sine series cell
// Derives the next Taylor term from the previous and adds it with sign (-1)^K.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtc_sine_cell
    import rtc_pkg::*;
#(
    parameter int K = 1
)
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire sine_term_t cell_in,
    output sine_term_t      cell_out
);

    localparam longint unsigned DIVISOR     = 2 * K * (2 * K + 1);
    localparam int              LOG_DIV     = $clog2(DIVISOR + 1) - 1;
    localparam int              RECIP_SHIFT = 32 + LOG_DIV;
    localparam logic [63:0]     RECIP       = (64'd1 << RECIP_SHIFT) / DIVISOR;
    localparam logic [31:0]     RECIP_MUL   = RECIP[31:0];
    localparam logic [32:0]     DIV_W       = 33'(DIVISOR);

    logic [62:0]        prod1_next;
    logic [32:0]        n1_reg;
    logic [31:0]        t2_1_reg;
    logic signed [33:0] sum1_reg;

    logic [71:0]        prod2_next;
    logic [30:0]        q0_reg;
    logic [32:0]        n2_reg;
    logic [31:0]        t2_2_reg;
    logic signed [33:0] sum2_reg;

    logic [32:0]        rem_next;
    logic [30:0]        q_next;
    sine_term_t         out_reg;

    assign prod1_next = 63'(cell_in.term) * 63'(cell_in.t2);
    assign prod2_next = 72'(n1_reg) * 72'(RECIP_MUL);
    assign rem_next   = n2_reg - 33'(q0_reg) * DIV_W;
    assign q_next     = q0_reg + 31'(rem_next >= DIV_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= prod1_next[62:30];
            t2_1_reg <= cell_in.t2;
            sum1_reg <= cell_in.sum;

            q0_reg   <= prod2_next[RECIP_SHIFT +: 31];
            n2_reg   <= n1_reg;
            t2_2_reg <= t2_1_reg;
            sum2_reg <= sum1_reg;

            out_reg.term <= q_next;
            out_reg.t2   <= t2_2_reg;
            if (K % 2 == 1)
            begin
                out_reg.sum <= sum2_reg - $signed({3'b000, q_next});
            end
            else
            begin
                out_reg.sum <= sum2_reg + $signed({3'b000, q_next});
            end
        end
    end

    assign cell_out = out_reg;

endmodule

`default_nettype wire

>>> hdl/rtc_sine_unit.sv
// ----------------------------------------------------------------------------
// Sine unit
// Folds a binary angle into one quadrant and evaluates its sine magnitude in
// Q30 through a chain of series cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtc_sine_unit
    import rtc_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output logic [30:0]                mag
);

    localparam int                QS      = ANGLE_BITS - 2;
    localparam logic [QS:0]       QUARTER = (QS + 1)'(1) << QS;
    localparam logic [QS+31:0]    HALF_Q  = (QS + 32)'(1) << (QS - 1);

    logic [QS:0]        arg_next;
    logic [QS+31:0]     scaled_next;
    logic [30:0]        t_reg;
    logic [61:0]        sq_next;
    sine_term_t         head_reg;
    sine_term_t         link [0:TERM_COUNT];
    logic [30:0]        mag_reg;

    assign arg_next    = angle[ANGLE_BITS-2] ? (QUARTER - {1'b0, angle[QS-1:0]})
                                             : {1'b0, angle[QS-1:0]};
    assign scaled_next = (QS + 32)'(arg_next) * (QS + 32)'(HALF_PI_Q30) + HALF_Q;
    assign sq_next     = 62'(t_reg) * 62'(t_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg         <= scaled_next[QS +: 31];
            head_reg.term <= t_reg;
            head_reg.t2   <= sq_next[61:30];
            head_reg.sum  <= $signed({3'b000, t_reg});
        end
    end

    assign link[0] = head_reg;

    for (genvar k = 1; k <= TERM_COUNT; k++)
    begin : g_cell
        rtc_sine_cell #(
            .K (k)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .cell_in  (link[k-1]),
            .cell_out (link[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (link[TERM_COUNT].sum[33])
            begin
                mag_reg <= '0;
            end
            else if (link[TERM_COUNT].sum > $signed({3'b000, ONE_Q30}))
            begin
                mag_reg <= ONE_Q30;
            end
            else
            begin
                mag_reg <= link[TERM_COUNT].sum[30:0];
            end
        end
    end

    assign mag = mag_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Range to Cartesian point unit testbench
// Streams range samples with binary angles through the unit under bursty
// input and stalled output, predicts each point in fixed point and compares
// x, y, z and the valid flag in order, across several minimum range settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rtc_pkg::*;

    localparam int LATENCY = 27;

    typedef struct packed {
        logic [15:0] phi;
        logic [15:0] theta;
        logic [14:0] range;
    } sample_t;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
        logic        ok;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    sample_t     pending_samples[$];
    point_t      expected_points[$];
    logic [14:0] min_range_q;
    int          error_count;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    bit          hold_input;

    range_to_cartesian_point_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    function automatic longint unsigned quadrant_sine(longint unsigned u);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        t = (u * 64'd1686629713 + 64'd8192) >> 14;
        t2 = (t * t) >> 30;
        term = t;
        sum = t;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * t2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'd1 << 30))
            sum = 64'd1 << 30;
        return sum;
    endfunction

    function automatic longint unsigned angle_sine(logic [15:0] a, output bit neg);
        logic [1:0]      q;
        longint unsigned u;
        longint unsigned m;
        q = a[15:14];
        u = 64'(a[13:0]);
        m = q[0] ? quadrant_sine(64'd16384 - u) : quadrant_sine(u);
        neg = q[1] && (m != 0);
        return m;
    endfunction

    function automatic longint unsigned round_q30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [15:0] signed_coord(longint unsigned mag, bit neg);
        if (mag > 32767)
            mag = 32767;
        if (neg && mag != 0)
            return 16'(-mag);
        return 16'(mag);
    endfunction

    function automatic point_t convert_sample(sample_t s, logic [14:0] min_r);
        point_t          p;
        bit              sth_n, cth_n, sph_n, cph_n;
        longint unsigned sth, cth, sph, cph;
        p = '0;
        if (s.range <= min_r)
            return p;
        sth = angle_sine(s.theta, sth_n);
        cth = angle_sine(16'(s.theta + 16'd16384), cth_n);
        sph = angle_sine(s.phi, sph_n);
        cph = angle_sine(16'(s.phi + 16'd16384), cph_n);
        p.x = signed_coord(round_q30(round_q30(cph, sth), 64'(s.range)), cph_n != sth_n);
        p.y = signed_coord(round_q30(sph, 64'(s.range)), sph_n);
        p.z = signed_coord(round_q30(round_q30(cph, cth), 64'(s.range)), cph_n != cth_n);
        p.ok = 1'b1;
        return p;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            logic    fire;
            sample_t s;
            fire = s_tvalid && s_tready;
            if (fire)
                expected_points.insert(expected_points.size(),
                                       convert_sample(sample_t'(s_tdata[46:0]), min_range_q));
            if (!s_tvalid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0 && !hold_input)
                begin
                    s = pending_samples.pop_front();
                    s_tdata  <= {1'b0, s};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern varying with a slowly drifting phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            point_t got;
            point_t want;
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tuser[0]};
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected point x=%h y=%h z=%h ok=%b", $time,
                             got.x, got.y, got.z, got.ok);
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.x !== want.x)
                    begin
                        $display("%0t: x expected %h actual %h", $time, want.x, got.x);
                        error_count++;
                    end
                    if (got.y !== want.y)
                    begin
                        $display("%0t: y expected %h actual %h", $time, want.y, got.y);
                        error_count++;
                    end
                    if (got.z !== want.z)
                    begin
                        $display("%0t: z expected %h actual %h", $time, want.z, got.z);
                        error_count++;
                    end
                    if (got.ok !== want.ok)
                    begin
                        $display("%0t: valid expected %b actual %b", $time, want.ok, got.ok);
                        error_count++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            case ((stall_phase >> 7) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_min_range(logic [14:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        min_range_q = value;
    endtask

    function automatic sample_t random_sample(logic [14:0] min_r);
        sample_t s;
        s.theta = 16'($urandom);
        s.phi   = 16'($urandom);
        case ($urandom_range(0, 9))
            0: s.range = 15'($urandom_range(0, min_r));
            1: s.range = (min_r < 15'd32767) ? 15'(min_r + 15'd1) : 15'd32767;
            2: s.range = 15'(32767 - $urandom_range(0, 3));
            3: s.range = 15'($urandom_range(0, 100));
            default: s.range = 15'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0)
            s.theta = 16'($urandom_range(0, 3)) << 14;
        if ($urandom_range(0, 7) == 0)
            s.phi = 16'($urandom_range(0, 3)) << 14;
        return s;
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_samples.insert(pending_samples.size(), random_sample(min_range_q));
    endtask

    initial
    begin
        logic [14:0] settings[4];
        sample_t     s;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        hold_input  = 1'b0;
        error_count = 0;
        min_range_q = MIN_RANGE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset threshold, quadrant edges, extremes and wrap of angles.
        foreach (settings[i])
            settings[i] = '0;
        for (int r = 0; r < 6; r++)
        begin
            s.range = (r == 0) ? 15'd0 : (r == 1) ? 15'd19 : (r == 2) ? 15'd20 :
                      (r == 3) ? 15'd32767 : (r == 4) ? 15'd1000 : 15'd12345;
            s.theta = (r % 2) ? 16'h8000 : 16'h7fff;
            s.phi   = (r < 3) ? 16'h0000 : 16'hc000;
            pending_samples.insert(pending_samples.size(), s);
        end
        for (int q = 0; q < 8; q++)
        begin
            s.range = 15'd32767;
            s.theta = 16'(q) << 13;
            s.phi   = 16'hffff - (16'(q) << 13);
            pending_samples.insert(pending_samples.size(), s);
        end
        s = '{phi: 16'h4000, theta: 16'hffff, range: 15'd5000};
        pending_samples.insert(pending_samples.size(), s);
        s = '{phi: 16'h8000, theta: 16'h0001, range: 15'd5000};
        pending_samples.insert(pending_samples.size(), s);
        s = '{phi: 16'h5555, theta: 16'haaaa, range: 15'h5555};
        pending_samples.insert(pending_samples.size(), s);
        s = '{phi: 16'haaaa, theta: 16'h5555, range: 15'h2aaa};
        pending_samples.insert(pending_samples.size(), s);
        queue_random(300);

        // Let part of the queue go out, then pause the sender until the pipeline has emptied.
        while (pending_samples.size() > 150)
            @(posedge clk);
        hold_input = 1'b1;
        while (expected_points.size() > 0 || s_tvalid)
            @(posedge clk);
        hold_input = 1'b0;
        wait_drained();

        settings[0] = 15'd0;
        settings[1] = 15'd32767;
        settings[2] = 15'd16384;
        settings[3] = 15'd500;
        foreach (settings[i])
        begin
            write_min_range(settings[i]);
            queue_random(160);
            wait_drained();
        end

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/rtc_pkg.sv
hdl/rtc_sine_cell.sv
hdl/rtc_sine_unit.sv
hdl/range_to_cartesian_point_unit.sv
tb/tb.sv
